// File: hdl/motion_primitive_expand_cost_defines.svh
// Assertion macros for the motion primitive expansion block.
// Used by the port checker; depends on nothing else.
`ifndef MOTION_PRIMITIVE_EXPAND_COST_DEFINES_SVH
`define MOTION_PRIMITIVE_EXPAND_COST_DEFINES_SVH

// Same-cycle implication, switched off while reset is high
`define MPEC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, switched off while reset is high
`define MPEC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also runs across reset
`define MPEC_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/mpec_pkg.sv
// Shared types and constants of the motion primitive expansion block.
// Used by the trig ROM, the top level and the port checker; no dependencies.
package mpec_pkg;

   // Field widths
   localparam int POSE_W   = 19;
   localparam int CHILD_W  = 20;
   localparam int HEAD_W   = 7;
   localparam int PRIM_W   = 3;
   localparam int CELL_W   = 8;
   localparam int COST_W   = 24;
   localparam int STEP_W   = 12;
   localparam int WEIGHT_W = 16;

   // Trig ROM words: signed Q2.14
   localparam int TRIG_W    = 16;
   localparam int TRIG_FRAC = 14;

   // Stream packing
   localparam int REQ_TDATA_W  = 56;
   localparam int REQ_TUSER_W  = 6;
   localparam int RSP_TDATA_W  = 72;
   localparam int REQ_X_LSB    = 0;
   localparam int REQ_Y_LSB    = 19;
   localparam int REQ_HEAD_LSB = 38;
   localparam int REQ_CELL_LSB = 45;
   localparam int REQ_PRIM_LSB = 0;
   localparam int REQ_PAR_LSB  = 3;
   localparam int RSP_X_LSB    = 0;
   localparam int RSP_Y_LSB    = 20;
   localparam int RSP_HEAD_LSB = 40;
   localparam int RSP_COST_LSB = 47;

   // Register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;

   // Arithmetic constants
   localparam logic [63:0]         HALF_PI_Q30 = 64'd1686629713;
   localparam logic [16:0]         SQRT2_Q16   = 17'd92682;
   localparam logic [COST_W-1:0]   SQRT2_Q8    = 24'd362;
   localparam logic [COST_W-1:0]   COST_MAX    = 24'hFFFFFF;
   localparam logic [WEIGHT_W:0]   UNITY_Q8    = 17'd256;
   localparam logic [25:0]         RECIP63     = 26'd34087042;
   localparam logic [5:0]          DIV63       = 6'd63;
   localparam logic [4:0]          DIV63_BIAS  = 5'd31;

   // Motion primitives
   typedef enum logic [PRIM_W-1:0] {
      PRIM_FWD        = 3'd0,
      PRIM_FWD_LEFT   = 3'd1,
      PRIM_FWD_RIGHT  = 3'd2,
      PRIM_BACK       = 3'd3,
      PRIM_BACK_LEFT  = 3'd4,
      PRIM_BACK_RIGHT = 3'd5,
      PRIM_START      = 3'd6
   } prim_type;

   // Register indexes
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_STEP_ALONG      = 3'd0,
      CSR_STEP_SIDE       = 3'd1,
      CSR_STEP_STRAIGHT   = 3'd2,
      CSR_TURN_BINS       = 3'd3,
      CSR_CELL_WEIGHT     = 3'd4,
      CSR_TURN_WEIGHT     = 3'd5,
      CSR_SWITCH_WEIGHT   = 3'd6,
      CSR_BACKWARD_WEIGHT = 3'd7
   } csr_index_type;

endpackage

// File: hdl/motion_primitive_expand_cost.sv
// Throughput: one request per cycle while the result channel is not stalled;
// five register stages, the trig ROM read in stage two and the cost product
// built over stages two to five.
// A stage holds only while it is full and the stage after it is stalled.
// Reset (synchronous, active high) empties every stage and loads the
// register defaults; there is no clearing pass.
module motion_primitive_expand_cost #(
   parameter int NUM_BINS = 72
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [18:0] pose_x, [37:19] pose_y, [44:38] heading_bin,
   // [52:45] child_cell_cost, [55:53] zero
   input  logic [mpec_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // [2:0] primitive_req, [5:3] parent_primitive
   input  logic [mpec_pkg::REQ_TUSER_W-1:0]     req_tuser,
   // result channel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [19:0] child_x, [39:20] child_y, [46:40] child_heading,
   // [70:47] step_cost, [71] zero
   output logic [mpec_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // [0] cost_saturated
   output logic                                 rsp_tuser,
   // register write channel
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [mpec_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [mpec_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import mpec_pkg::*;

   localparam int IDX_W = $clog2(NUM_BINS);
   localparam int Q_W   = 20;
   localparam int RAW_W = 25;
   localparam int WB_W  = 34;
   localparam int PP_W  = RAW_W + 17;
   localparam int PR_W  = STEP_W + 1 + TRIG_W;

   typedef logic [IDX_W-1:0] mod_arr_type [2**HEAD_W];

   // Residue of every seven-bit value modulo NUM_BINS
   function automatic mod_arr_type build_mod();
      mod_arr_type t;
      for (int i = 0; i < 2**HEAD_W; i++) begin
         t[i] = IDX_W'(i % NUM_BINS);
      end
      return t;
   endfunction

   localparam mod_arr_type MOD_TAB = build_mod();

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [STEP_W-1:0]   step_along_ff, step_side_ff, step_straight_ff;
   logic [HEAD_W-1:0]   turn_bins_ff;
   logic [WEIGHT_W-1:0] cell_weight_ff, turn_weight_ff, switch_weight_ff;
   logic [WEIGHT_W-1:0] backward_weight_ff;

   assign csr_ready = 1'b1;

   // Take a write whenever one is offered
   always_ff @(posedge clock) begin
      if (reset) begin
         step_along_ff      <= '0;
         step_side_ff       <= '0;
         step_straight_ff   <= '0;
         turn_bins_ff       <= 7'd1;
         cell_weight_ff     <= 16'd435;
         turn_weight_ff     <= 16'd269;
         switch_weight_ff   <= 16'd512;
         backward_weight_ff <= 16'd512;
      end else if (csr_valid) begin
         unique case (csr_addr)
            CSR_STEP_ALONG:      step_along_ff      <= csr_wdata[STEP_W-1:0];
            CSR_STEP_SIDE:       step_side_ff       <= csr_wdata[STEP_W-1:0];
            CSR_STEP_STRAIGHT:   step_straight_ff   <= csr_wdata[STEP_W-1:0];
            CSR_TURN_BINS:       turn_bins_ff       <= csr_wdata[HEAD_W-1:0];
            CSR_CELL_WEIGHT:     cell_weight_ff     <= csr_wdata;
            CSR_TURN_WEIGHT:     turn_weight_ff     <= csr_wdata;
            CSR_SWITCH_WEIGHT:   switch_weight_ff   <= csr_wdata;
            CSR_BACKWARD_WEIGHT: backward_weight_ff <= csr_wdata;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Pipeline control: a stage moves when empty or when the next moves
   // ------------------------------------------------------------------
   logic [5:1] v_ff;
   logic [6:1] adv;

   always_comb begin
      adv[6] = rsp_tready;
      for (int k = 5; k >= 1; k--) begin
         adv[k] = !v_ff[k] || adv[k+1];
      end
   end

   assign req_tready = adv[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (adv[1]) v_ff[1] <= req_tvalid;
         for (int k = 2; k <= 5; k++) begin
            if (adv[k]) v_ff[k] <= v_ff[k-1];
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: unpack, decode the primitive, cell product, heading residues
   // ------------------------------------------------------------------
   logic signed [POSE_W-1:0] req_x, req_y;
   logic [HEAD_W-1:0]        req_head;
   logic [CELL_W-1:0]        req_cell;
   logic [PRIM_W-1:0]        req_prim, req_par;

   assign req_x    = $signed(req_tdata[REQ_X_LSB +: POSE_W]);
   assign req_y    = $signed(req_tdata[REQ_Y_LSB +: POSE_W]);
   assign req_head = req_tdata[REQ_HEAD_LSB +: HEAD_W];
   assign req_cell = req_tdata[REQ_CELL_LSB +: CELL_W];
   assign req_prim = req_tuser[REQ_PRIM_LSB +: PRIM_W];
   assign req_par  = req_tuser[REQ_PAR_LSB +: PRIM_W];

   logic signed [STEP_W:0]  a_in, s_in;
   logic                    turn_pos, turn_neg, straight;
   logic [WEIGHT_W:0]       w_in, b_in;
   logic [IDX_W-1:0]        tb_mod, tm_in;
   logic                    start_in;

   // Signed displacement and turn direction of the chosen primitive
   always_comb begin
      a_in     = '0;
      s_in     = '0;
      turn_pos = 1'b0;
      turn_neg = 1'b0;
      case (req_prim)
         PRIM_FWD: begin
            a_in = $signed({1'b0, step_straight_ff});
         end
         PRIM_FWD_LEFT: begin
            a_in     = $signed({1'b0, step_along_ff});
            s_in     = $signed({1'b0, step_side_ff});
            turn_pos = 1'b1;
         end
         PRIM_FWD_RIGHT: begin
            a_in     = $signed({1'b0, step_along_ff});
            s_in     = -$signed({1'b0, step_side_ff});
            turn_neg = 1'b1;
         end
         PRIM_BACK: begin
            a_in = -$signed({1'b0, step_straight_ff});
         end
         PRIM_BACK_LEFT: begin
            a_in     = -$signed({1'b0, step_along_ff});
            s_in     = $signed({1'b0, step_side_ff});
            turn_neg = 1'b1;
         end
         PRIM_BACK_RIGHT: begin
            a_in     = -$signed({1'b0, step_along_ff});
            s_in     = -$signed({1'b0, step_side_ff});
            turn_pos = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Penalty factors: motion weight and reverse weight
   always_comb begin
      straight = (req_prim == PRIM_FWD) || (req_prim == PRIM_BACK);
      if (straight) begin
         w_in = UNITY_Q8;
      end else if (req_par == req_prim) begin
         w_in = {1'b0, turn_weight_ff};
      end else begin
         w_in = {1'b0, switch_weight_ff} + {1'b0, turn_weight_ff};
      end
      if (req_par == PRIM_BACK || req_par == PRIM_BACK_LEFT ||
          req_par == PRIM_BACK_RIGHT) begin
         b_in = {1'b0, backward_weight_ff};
      end else begin
         b_in = UNITY_Q8;
      end
      start_in = (req_par >= PRIM_START);
   end

   // Turn offset as a residue in 0..NUM_BINS-1
   always_comb begin
      tb_mod = MOD_TAB[turn_bins_ff];
      if (turn_pos) begin
         tm_in = tb_mod;
      end else if (turn_neg && tb_mod != '0) begin
         tm_in = IDX_W'(NUM_BINS) - tb_mod;
      end else begin
         tm_in = '0;
      end
   end

   logic signed [POSE_W-1:0]       x1_ff, y1_ff;
   logic signed [STEP_W:0]         a1_ff, s1_ff;
   logic [IDX_W-1:0]               hm1_ff, tm1_ff;
   logic [WEIGHT_W+CELL_W-1:0]     p1_ff;
   logic [WEIGHT_W:0]              w1_ff, b1_ff;
   logic                           start1_ff;

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         x1_ff     <= req_x;
         y1_ff     <= req_y;
         a1_ff     <= a_in;
         s1_ff     <= s_in;
         hm1_ff    <= MOD_TAB[req_head];
         tm1_ff    <= tm_in;
         p1_ff     <= cell_weight_ff * req_cell;
         w1_ff     <= w_in;
         b1_ff     <= b_in;
         start1_ff <= start_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: ROM read, heading wrap, quotient estimate, weight product
   // ------------------------------------------------------------------
   logic signed [TRIG_W-1:0] sin2, cos2;

   mpec_trig_rom #(
      .NUM_BINS (NUM_BINS)
   ) u_trig_rom (
      .clock  (clock),
      .rd_en  (adv[2]),
      .rd_idx (hm1_ff),
      .rd_sin (sin2),
      .rd_cos (cos2)
   );

   logic [IDX_W:0]        hsum;
   logic [IDX_W-1:0]      h2_in;
   logic [RAW_W-1:0]      n2;
   logic [RAW_W+25:0]     q_prod;

   always_comb begin
      hsum = {1'b0, hm1_ff} + {1'b0, tm1_ff};
      if (hsum >= (IDX_W+1)'(NUM_BINS)) begin
         h2_in = IDX_W'(hsum - (IDX_W+1)'(NUM_BINS));
      end else begin
         h2_in = hsum[IDX_W-1:0];
      end
      n2     = {1'b0, p1_ff} + RAW_W'(DIV63_BIAS);
      q_prod = n2 * RECIP63;
   end

   logic signed [POSE_W-1:0]   x2_ff, y2_ff;
   logic signed [STEP_W:0]     a2_ff, s2_ff;
   logic [IDX_W-1:0]           h2_ff;
   logic [WEIGHT_W+CELL_W-1:0] p2_ff;
   logic [Q_W-1:0]             q2_ff;
   logic [WB_W-1:0]            wb2_ff;
   logic                       start2_ff;

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         x2_ff     <= x1_ff;
         y2_ff     <= y1_ff;
         a2_ff     <= a1_ff;
         s2_ff     <= s1_ff;
         h2_ff     <= h2_in;
         p2_ff     <= p1_ff;
         q2_ff     <= q_prod[RAW_W+25:31];
         wb2_ff    <= w1_ff * b1_ff;
         start2_ff <= start1_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: rotation products, quotient correction, raw cost
   // ------------------------------------------------------------------
   logic signed [PR_W-1:0] ac_in, ss_in, as_in, sc_in;
   logic [RAW_W-1:0]       n3;
   logic [RAW_W:0]         m63, rem;
   logic [RAW_W-1:0]       raw_in;

   always_comb begin
      ac_in  = a2_ff * cos2;
      ss_in  = s2_ff * sin2;
      as_in  = a2_ff * sin2;
      sc_in  = s2_ff * cos2;
      n3     = {1'b0, p2_ff} + RAW_W'(DIV63_BIAS);
      m63    = {q2_ff, 6'b0} - (RAW_W+1)'(q2_ff);
      rem    = {1'b0, n3} - m63;
      raw_in = RAW_W'(SQRT2_Q16) + RAW_W'(p2_ff) + RAW_W'(q2_ff)
             + RAW_W'(rem >= (RAW_W+1)'(DIV63));
   end

   logic signed [POSE_W-1:0] x3_ff, y3_ff;
   logic signed [PR_W-1:0]   ac3_ff, ss3_ff, as3_ff, sc3_ff;
   logic [IDX_W-1:0]         h3_ff;
   logic [RAW_W-1:0]         raw3_ff;
   logic [WB_W-1:0]          wb3_ff;
   logic                     start3_ff;

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         x3_ff     <= x2_ff;
         y3_ff     <= y2_ff;
         ac3_ff    <= ac_in;
         ss3_ff    <= ss_in;
         as3_ff    <= as_in;
         sc3_ff    <= sc_in;
         h3_ff     <= h2_ff;
         raw3_ff   <= raw_in;
         wb3_ff    <= wb2_ff;
         start3_ff <= start2_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: round the displacement to Q8, cost partial products
   // ------------------------------------------------------------------
   logic signed [PR_W:0]   vx, vy, vx_r, vy_r;

   // Round half away from zero: bias negatives one less
   always_comb begin
      vx   = (PR_W+1)'(ac3_ff) - (PR_W+1)'(ss3_ff);
      vy   = (PR_W+1)'(as3_ff) + (PR_W+1)'(sc3_ff);
      vx_r = vx + (vx[PR_W] ? (PR_W+1)'(8191) : (PR_W+1)'(8192));
      vy_r = vy + (vy[PR_W] ? (PR_W+1)'(8191) : (PR_W+1)'(8192));
   end

   logic signed [POSE_W-1:0]      x4_ff, y4_ff;
   logic signed [PR_W-TRIG_FRAC:0] dx4_ff, dy4_ff;
   logic [IDX_W-1:0]              h4_ff;
   logic [PP_W-1:0]               pplo4_ff, pphi4_ff;
   logic                          start4_ff;

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         x4_ff     <= x3_ff;
         y4_ff     <= y3_ff;
         dx4_ff    <= vx_r[PR_W:TRIG_FRAC];
         dy4_ff    <= vy_r[PR_W:TRIG_FRAC];
         h4_ff     <= h3_ff;
         pplo4_ff  <= raw3_ff * wb3_ff[16:0];
         pphi4_ff  <= raw3_ff * wb3_ff[WB_W-1:17];
         start4_ff <= start3_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 5: child pose, cost sum, round to Q8, saturate
   // ------------------------------------------------------------------
   logic [PP_W+17:0]     tc, tc_r;
   logic [PP_W-7:0]      cost_wide;
   logic                 sat_in;
   logic [COST_W-1:0]    cost_in;

   always_comb begin
      tc        = (PP_W+18)'(pplo4_ff) + {1'b0, pphi4_ff, 17'b0};
      tc_r      = tc + (PP_W+18)'(24'h800000);
      cost_wide = tc_r[PP_W+17:24];
      if (start4_ff) begin
         sat_in  = 1'b0;
         cost_in = SQRT2_Q8;
      end else if (|cost_wide[PP_W-7:COST_W]) begin
         sat_in  = 1'b1;
         cost_in = COST_MAX;
      end else begin
         sat_in  = 1'b0;
         cost_in = cost_wide[COST_W-1:0];
      end
   end

   logic [CHILD_W-1:0] x5_ff, y5_ff;
   logic [IDX_W-1:0]   h5_ff;
   logic [COST_W-1:0]  cost5_ff;
   logic               sat5_ff;

   always_ff @(posedge clock) begin
      if (adv[5]) begin
         x5_ff    <= CHILD_W'(x4_ff) + CHILD_W'(dx4_ff);
         y5_ff    <= CHILD_W'(y4_ff) + CHILD_W'(dy4_ff);
         h5_ff    <= h4_ff;
         cost5_ff <= cost_in;
         sat5_ff  <= sat_in;
      end
   end

   // Pack the result
   always_comb begin
      rsp_tdata                              = '0;
      rsp_tdata[RSP_X_LSB +: CHILD_W]        = x5_ff;
      rsp_tdata[RSP_Y_LSB +: CHILD_W]        = y5_ff;
      rsp_tdata[RSP_HEAD_LSB +: HEAD_W]      = HEAD_W'(h5_ff);
      rsp_tdata[RSP_COST_LSB +: COST_W]      = cost5_ff;
   end

   assign rsp_tuser  = sat5_ff;
   assign rsp_tvalid = v_ff[5];

endmodule

// File: hdl/mpec_trig_rom.sv
// Sine and cosine ROM of NUM_BINS entries, signed Q2.14, registered read.
// Contents are built at elaboration; depends on mpec_pkg.
module mpec_trig_rom #(
   parameter int NUM_BINS = 72
) (
   input  logic                                    clock,
   input  logic                                    rd_en,
   input  logic [$clog2(NUM_BINS)-1:0]             rd_idx,
   output logic signed [mpec_pkg::TRIG_W-1:0]      rd_sin,
   output logic signed [mpec_pkg::TRIG_W-1:0]      rd_cos
);
   import mpec_pkg::*;

   typedef logic signed [TRIG_W-1:0] trig_arr_type [NUM_BINS];

   // Quarter-wave sine, odd series to the thirteenth power in Q30
   function automatic logic signed [TRIG_W-1:0] quarter_sine(input logic [31:0] u);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      x    = (64'(u) * HALF_PI_Q30) / 64'(NUM_BINS);
      x2   = (x * x) >> 30;
      sum  = $signed(x);
      term = ((x * x2) >> 30) / 64'd6;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + $signed(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - $signed(term);
      term = ((term * x2) >> 30) / 64'd156;
      sum  = sum + $signed(term);
      if (sum < 0) begin
         sum = '0;
      end
      return TRIG_W'((64'(sum) + 64'd32768) >> 16);
   endfunction

   // Full-wave table, one quadrant select per entry
   function automatic trig_arr_type build_table(input logic want_cos);
      trig_arr_type       t;
      logic [31:0]        q;
      logic [31:0]        r;
      logic signed [TRIG_W-1:0] a;
      logic signed [TRIG_W-1:0] b;
      for (int k = 0; k < NUM_BINS; k++) begin
         q = 32'((4 * k) / NUM_BINS);
         r = 32'(4 * k) - q * 32'(NUM_BINS);
         a = quarter_sine(r);
         b = quarter_sine(32'(NUM_BINS) - r);
         case (q[1:0])
            2'd0:    t[k] = want_cos ? b : a;
            2'd1:    t[k] = want_cos ? -a : b;
            2'd2:    t[k] = want_cos ? -b : -a;
            default: t[k] = want_cos ? a : -b;
         endcase
      end
      return t;
   endfunction

   localparam trig_arr_type SIN_ROM = build_table(1'b0);
   localparam trig_arr_type COS_ROM = build_table(1'b1);

   logic signed [TRIG_W-1:0] sin_ff;
   logic signed [TRIG_W-1:0] cos_ff;

   // Read both words when the stage advances
   always_ff @(posedge clock) begin
      if (rd_en) begin
         sin_ff <= SIN_ROM[rd_idx];
         cos_ff <= COS_ROM[rd_idx];
      end
   end

   assign rd_sin = sin_ff;
   assign rd_cos = cos_ff;

endmodule

// File: hdl/mpec_checker.sv
// Port checker for the motion primitive expansion block, bound to the top.
// Depends on mpec_pkg and motion_primitive_expand_cost_defines.svh.
`include "motion_primitive_expand_cost_defines.svh"

module mpec_checker #(
   parameter int NUM_BINS = 72
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [mpec_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input logic                              rsp_tuser
);
   import mpec_pkg::*;

   // Hold a stalled result unchanged
   `MPEC_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled result changed")

   // A clipped cost reads as the maximum
   `MPEC_ASSERT_IMP(a_sat_max, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata[RSP_COST_LSB +: COST_W] == COST_MAX, "saturation flag without maximum cost")

   // Heading stays wrapped
   `MPEC_ASSERT_IMP(a_head_range, clock, reset, rsp_tvalid, rsp_tdata[RSP_HEAD_LSB +: HEAD_W] < NUM_BINS, "child heading not wrapped")

   // An empty output stage never blocks requests
   `MPEC_ASSERT_IMP(a_ready_free, clock, reset, !rsp_tvalid, req_tready, "request stalled with empty output")

   // Drop every result on reset
   `MPEC_ASSERT_ALWAYS(a_reset_empty, clock, reset, !rsp_tvalid, "result valid after reset")

endmodule

bind motion_primitive_expand_cost mpec_checker #(.NUM_BINS(NUM_BINS)) u_mpec_checker (.*);
